// ===== hdl/flpa_pkg.sv =====
// ----------------------------------------------------------------------------
// flpa_pkg
// Shared types, sizes and codes for the free-list pool allocator.
// ----------------------------------------------------------------------------
package flpa_pkg;

	localparam int ENTRIES = 1024;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int POOL_W  = $clog2(ENTRIES + 1);
	localparam int SUM_W   = POOL_W + 1;
	// link word: end-of-list mark on top of an entry index
	localparam int LINK_W  = IDX_W + 1;
	localparam logic [LINK_W-1:0] END_LINK = {1'b1, {IDX_W{1'b0}}};

	localparam int SIZE_W  = 16;
	localparam int CHUNK_W = 11;
	localparam int CNT_W   = 32;
	localparam int HANDLE_W = 10;
	localparam int FIDX_W  = 10;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic [1:0] REG_OBJECT_SIZE  = 2'd0;
	localparam logic [1:0] REG_START_CHUNK  = 2'd1;
	localparam logic [1:0] REG_EXPAND_CHUNK = 2'd2;
	localparam logic [1:0] REG_MAX_POOL     = 2'd3;

	localparam logic [SIZE_W-1:0]  RST_OBJECT_SIZE  = 16'd64;
	localparam logic [CHUNK_W-1:0] RST_START_CHUNK  = 11'd64;
	localparam logic [CHUNK_W-1:0] RST_EXPAND_CHUNK = 11'd32;
	localparam logic [CHUNK_W-1:0] RST_MAX_POOL     = 11'd1024;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERSIZE = 2'd1;
	localparam logic [1:0] STAT_LIMIT    = 2'd2;
	localparam logic [1:0] STAT_NULL     = 2'd3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0]  object_size;
		logic [CHUNK_W-1:0] start_chunk;
		logic [CHUNK_W-1:0] expand_chunk;
		logic [CHUNK_W-1:0] max_pool;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [LINK_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_GROW,
		ST_SETTLE
	} state_t;

	typedef enum logic [1:0] {
		OP_RESP,
		OP_GROW,
		OP_POP,
		OP_PUSH
	} op_t;

endpackage

// ===== hdl/flpa_ram.sv =====
// ----------------------------------------------------------------------------
// flpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module flpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/flpa_regs.sv =====
// ----------------------------------------------------------------------------
// flpa_regs
// APB configuration registers: object size, chunk sizes and pool limit.
// ----------------------------------------------------------------------------
module flpa_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [flpa_pkg::ADDR_W-1:0] paddr,
	input  logic [flpa_pkg::DATA_W-1:0] pwdata,
	output logic [flpa_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output flpa_pkg::cfg_t              cfg
);

	flpa_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.object_size  <= flpa_pkg::RST_OBJECT_SIZE;
			cfg_q.start_chunk  <= flpa_pkg::RST_START_CHUNK;
			cfg_q.expand_chunk <= flpa_pkg::RST_EXPAND_CHUNK;
			cfg_q.max_pool     <= flpa_pkg::RST_MAX_POOL;
		end else if (wr_en) begin
			case (reg_idx)
				flpa_pkg::REG_OBJECT_SIZE: begin
					cfg_q.object_size <= pwdata[flpa_pkg::SIZE_W-1:0];
				end
				flpa_pkg::REG_START_CHUNK: begin
					cfg_q.start_chunk <= pwdata[flpa_pkg::CHUNK_W-1:0];
				end
				flpa_pkg::REG_EXPAND_CHUNK: begin
					cfg_q.expand_chunk <= pwdata[flpa_pkg::CHUNK_W-1:0];
				end
				flpa_pkg::REG_MAX_POOL: begin
					cfg_q.max_pool <= pwdata[flpa_pkg::CHUNK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			flpa_pkg::REG_OBJECT_SIZE: begin
				prdata = flpa_pkg::DATA_W'(cfg_q.object_size);
			end
			flpa_pkg::REG_START_CHUNK: begin
				prdata = flpa_pkg::DATA_W'(cfg_q.start_chunk);
			end
			flpa_pkg::REG_EXPAND_CHUNK: begin
				prdata = flpa_pkg::DATA_W'(cfg_q.expand_chunk);
			end
			flpa_pkg::REG_MAX_POOL: begin
				prdata = flpa_pkg::DATA_W'(cfg_q.max_pool);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ===== hdl/flpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// flpa_ctrl
// Sequencer for the allocator: evaluates an item, grows the pool one link a
// cycle, pops and pushes the free list kept in the link memory.
// ----------------------------------------------------------------------------
module flpa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          action,
	input  logic [flpa_pkg::SIZE_W-1:0]   request_size,
	input  logic [flpa_pkg::FIDX_W-1:0]   free_index,
	input  logic                          free_null,
	input  flpa_pkg::cfg_t                cfg,
	input  logic [flpa_pkg::LINK_W-1:0]   rd_data,
	output flpa_pkg::mem_req_t            mem,
	output logic                          busy,
	output logic                          done,
	output logic [flpa_pkg::HANDLE_W-1:0] handle,
	output logic [1:0]                    status,
	output logic [flpa_pkg::POOL_W-1:0]   pool_size,
	output logic [flpa_pkg::CNT_W-1:0]    alloc_count,
	output logic [flpa_pkg::CNT_W-1:0]    free_count
);

	localparam int IDX_W  = flpa_pkg::IDX_W;
	localparam int POOL_W = flpa_pkg::POOL_W;
	localparam int SUM_W  = flpa_pkg::SUM_W;

	flpa_pkg::state_t state_q, state_d;
	flpa_pkg::op_t    op;
	logic [1:0]       resp_status;

	// latched item
	logic                         act_q;
	logic [flpa_pkg::SIZE_W-1:0]  req_q;
	logic [IDX_W-1:0]             fidx_q;
	logic                         fnull_q;

	// list and pool state
	logic [IDX_W-1:0]          head_q;
	logic                      nonempty_q;
	logic [POOL_W-1:0]         pool_q;
	logic [flpa_pkg::CNT_W-1:0] allocs_q;
	logic [flpa_pkg::CNT_W-1:0] frees_q;
	logic                      started_q;
	logic                      grown_q;

	// growth sequencing
	logic [POOL_W-1:0] base_q;
	logic [POOL_W-1:0] n_q;
	logic [POOL_W-1:0] cnt_q;
	logic              init_q;

	logic                       done_q;
	logic [flpa_pkg::HANDLE_W-1:0] handle_q;
	logic [1:0]                 status_q;

	logic                         accept;
	logic [flpa_pkg::CHUNK_W-1:0] grow_n;
	logic [SUM_W-1:0]             grow_total;
	logic                         grow_fail;
	logic [POOL_W-1:0]            cnt_inc;
	logic                         grow_last;
	logic                         grow_finish;
	logic [IDX_W-1:0]             grow_addr;

	assign accept     = start & (state_q == flpa_pkg::ST_IDLE);
	assign grow_n     = started_q ? cfg.expand_chunk : cfg.start_chunk;
	assign grow_total = SUM_W'(pool_q) + SUM_W'(grow_n);
	assign grow_fail  = (grow_total > SUM_W'(cfg.max_pool)) ||
		(grow_total > SUM_W'(flpa_pkg::ENTRIES));

	assign cnt_inc     = POOL_W'(cnt_q + POOL_W'(1));
	assign grow_last   = (cnt_inc == n_q);
	assign grow_finish = (n_q == '0) || grow_last;
	assign grow_addr   = IDX_W'(base_q + cnt_q);

	// decision taken in the evaluation cycle
	always_comb begin
		op          = flpa_pkg::OP_RESP;
		resp_status = flpa_pkg::STAT_OK;
		if (!started_q) begin
			if (grow_fail) begin
				resp_status = flpa_pkg::STAT_LIMIT;
			end else begin
				op = flpa_pkg::OP_GROW;
			end
		end else if (act_q == flpa_pkg::ACT_ALLOC) begin
			if (req_q > cfg.object_size) begin
				resp_status = flpa_pkg::STAT_OVERSIZE;
			end else if (nonempty_q) begin
				op = flpa_pkg::OP_POP;
			end else if (grown_q || grow_fail) begin
				// an empty growth cannot supply a block either
				resp_status = flpa_pkg::STAT_LIMIT;
			end else begin
				op = flpa_pkg::OP_GROW;
			end
		end else begin
			if (fnull_q) begin
				resp_status = flpa_pkg::STAT_NULL;
			end else begin
				op = flpa_pkg::OP_PUSH;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			flpa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = flpa_pkg::ST_EVAL;
				end
			end
			flpa_pkg::ST_EVAL: begin
				if (op == flpa_pkg::OP_GROW) begin
					state_d = flpa_pkg::ST_GROW;
				end else begin
					state_d = flpa_pkg::ST_IDLE;
				end
			end
			flpa_pkg::ST_GROW: begin
				if (grow_finish) begin
					state_d = flpa_pkg::ST_SETTLE;
				end
			end
			flpa_pkg::ST_SETTLE: begin
				// link memory read at the new head lands for the next evaluation
				state_d = flpa_pkg::ST_EVAL;
			end
			default: begin
				state_d = flpa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != flpa_pkg::ST_IDLE);
		mem.raddr = head_q;
		mem.we    = 1'b0;
		mem.waddr = grow_addr;
		mem.wdata = grow_last ? flpa_pkg::END_LINK :
			{1'b0, IDX_W'(base_q + cnt_inc)};
		case (state_q)
			flpa_pkg::ST_GROW: begin
				mem.we = (n_q != '0);
			end
			flpa_pkg::ST_EVAL: begin
				if (op == flpa_pkg::OP_PUSH) begin
					mem.we    = 1'b1;
					mem.waddr = fidx_q;
					mem.wdata = nonempty_q ? {1'b0, head_q} : flpa_pkg::END_LINK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			req_q   <= request_size;
			fidx_q  <= free_index[IDX_W-1:0];
			fnull_q <= free_null;
		end
		if ((state_q == flpa_pkg::ST_EVAL) && (op == flpa_pkg::OP_GROW)) begin
			base_q <= pool_q;
			n_q    <= POOL_W'(grow_n);
			init_q <= !started_q;
		end
		if (state_q == flpa_pkg::ST_GROW) begin
			cnt_q <= cnt_inc;
		end else begin
			cnt_q <= '0;
		end
		if ((state_q == flpa_pkg::ST_EVAL) && (op != flpa_pkg::OP_GROW)) begin
			status_q <= resp_status;
			handle_q <= (op == flpa_pkg::OP_POP) ? head_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			nonempty_q <= 1'b0;
			pool_q     <= '0;
			allocs_q   <= '0;
			frees_q    <= '0;
			started_q  <= 1'b0;
			grown_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				grown_q <= 1'b0;
			end
			case (state_q)
				flpa_pkg::ST_EVAL: begin
					done_q <= (op != flpa_pkg::OP_GROW);
					case (op)
						flpa_pkg::OP_POP: begin
							if (rd_data[IDX_W]) begin
								nonempty_q <= 1'b0;
								head_q     <= '0;
							end else begin
								head_q <= rd_data[IDX_W-1:0];
							end
							allocs_q <= allocs_q + flpa_pkg::CNT_W'(1);
						end
						flpa_pkg::OP_PUSH: begin
							head_q     <= fidx_q;
							nonempty_q <= 1'b1;
							frees_q    <= frees_q + flpa_pkg::CNT_W'(1);
						end
						default: begin
						end
					endcase
				end
				flpa_pkg::ST_GROW: begin
					if (grow_finish) begin
						if (n_q != '0) begin
							head_q     <= IDX_W'(base_q);
							nonempty_q <= 1'b1;
						end
						pool_q <= POOL_W'(base_q + n_q);
						if (init_q) begin
							started_q <= 1'b1;
						end else begin
							grown_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done        = done_q;
	assign handle      = handle_q;
	assign status      = status_q;
	assign pool_size   = pool_q;
	assign alloc_count = allocs_q;
	assign free_count  = frees_q;

	a_done_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == flpa_pkg::ST_EVAL))
		else $error("result beat without an evaluation cycle");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flpa_pkg::ST_IDLE || state_q == flpa_pkg::ST_SETTLE) |-> !mem.we)
		else $error("link memory written outside growth or push");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(pool_q) <= SUM_W'(flpa_pkg::ENTRIES))
		else $error("pool grew past the link memory depth");

	a_grow_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flpa_pkg::ST_GROW) |=>
		(state_q == flpa_pkg::ST_GROW || state_q == flpa_pkg::ST_SETTLE))
		else $error("growth left without the settle cycle");

endmodule

// ===== hdl/free_list_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_pool_allocator
// Fixed-size block pool with a LIFO free list held in a link memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low; its result appears for a
// single cycle with done high and must be captured then, as the block cannot
// be stalled. A free, a rejected request or an allocate from a non-empty list
// passes through the accept cycle, where the link memory is read at the list
// head, and an evaluation cycle; done follows and the next item may be taken
// in that same cycle. A growth of the pool (the first item after reset, or a
// fitting allocate that finds the list empty with room left under the cap)
// writes one new link a cycle into the link memory, then settles for the read
// at the new head and evaluates again. No clearing pass is run after reset.
// ----------------------------------------------------------------------------
module free_list_pool_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [flpa_pkg::ADDR_W-1:0]   paddr,
	input  logic [flpa_pkg::DATA_W-1:0]   pwdata,
	output logic [flpa_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [flpa_pkg::SIZE_W-1:0]   request_size,
	input  logic [flpa_pkg::FIDX_W-1:0]   free_index,
	input  logic                          free_null,
	output logic                          done,
	output logic [flpa_pkg::HANDLE_W-1:0] handle,
	output logic [1:0]                    status,
	output logic [flpa_pkg::POOL_W-1:0]   pool_size,
	output logic [flpa_pkg::CNT_W-1:0]    alloc_count,
	output logic [flpa_pkg::CNT_W-1:0]    free_count
);

	flpa_pkg::cfg_t                cfg;
	flpa_pkg::mem_req_t            mem;
	logic [flpa_pkg::LINK_W-1:0]   rd_data;

	flpa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	flpa_ram #(
		.WIDTH (flpa_pkg::LINK_W),
		.DEPTH (flpa_pkg::ENTRIES)
	) u_link_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rd_data)
	);

	flpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.request_size (request_size),
		.free_index   (free_index),
		.free_null    (free_null),
		.cfg          (cfg),
		.rd_data      (rd_data),
		.mem          (mem),
		.busy         (busy),
		.done         (done),
		.handle       (handle),
		.status       (status),
		.pool_size    (pool_size),
		.alloc_count  (alloc_count),
		.free_count   (free_count)
	);

endmodule

// ===== tb/free_list_pool_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_pool_allocator_tb
// Self-checking bench for the pool allocator: directed corner items, then
// randomised alloc/free traffic over several register settings. Each reply
// is predicted by a free-list tracker and compared field by field.
// ----------------------------------------------------------------------------
module free_list_pool_allocator_tb;

	import flpa_pkg::*;

	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [1:0]          status;
		logic [POOL_W-1:0]   pool;
		logic [CNT_W-1:0]    allocs;
		logic [CNT_W-1:0]    frees;
	} reply_t;

	class free_list_tracker;
		cfg_t              cfg;
		logic [LINK_W-1:0] links [ENTRIES];
		logic [IDX_W-1:0]  head;
		bit                listed;
		bit                started;
		int unsigned       pool;
		int unsigned       peak;
		logic [CNT_W-1:0]  allocs;
		logic [CNT_W-1:0]  frees;
		reply_t            replies_due [$];
		int unsigned       held_blocks [$];
		int unsigned       status_tally [4];
		int unsigned       requests;
		int unsigned       checked;
		int unsigned       reg_writes;
		int unsigned       mismatches;

		function new();
			cfg = {RST_OBJECT_SIZE, RST_START_CHUNK, RST_EXPAND_CHUNK, RST_MAX_POOL};
			foreach (links[i])
				links[i] = '0;
			head = '0;
			listed = 0;
			started = 0;
			pool = 0;
			peak = 0;
			allocs = '0;
			frees = '0;
			requests = 0;
			checked = 0;
			reg_writes = 0;
			mismatches = 0;
			foreach (status_tally[i])
				status_tally[i] = 0;
		endfunction

		function void flag(string msg);
			if (mismatches < 10)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endfunction

		function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_OBJECT_SIZE:  cfg.object_size  = value[SIZE_W-1:0];
				REG_START_CHUNK:  cfg.start_chunk  = value[CHUNK_W-1:0];
				REG_EXPAND_CHUNK: cfg.expand_chunk = value[CHUNK_W-1:0];
				REG_MAX_POOL:     cfg.max_pool     = value[CHUNK_W-1:0];
				default: ;
			endcase
			reg_writes++;
		endfunction

		function logic [DATA_W-1:0] reg_value(logic [1:0] idx);
			case (idx)
				REG_OBJECT_SIZE:  return DATA_W'(cfg.object_size);
				REG_START_CHUNK:  return DATA_W'(cfg.start_chunk);
				REG_EXPAND_CHUNK: return DATA_W'(cfg.expand_chunk);
				default:          return DATA_W'(cfg.max_pool);
			endcase
		endfunction

		// fresh entries become the whole list, linked in ascending order
		function bit grow(int unsigned n);
			int unsigned total;
			int unsigned idx;
			total = pool + n;
			if (total > cfg.max_pool || total > ENTRIES)
				return 0;
			for (int unsigned i = 0; i < n; i++) begin
				idx = pool + i;
				links[idx] = (i + 1 < n) ? {1'b0, IDX_W'(idx + 1)} : END_LINK;
			end
			if (n > 0) begin
				head = IDX_W'(pool);
				listed = 1;
			end
			pool = total;
			if (pool > peak)
				peak = pool;
			return 1;
		endfunction

		// one accepted beat: update the pool and queue the reply it must give
		function void take_request(logic act, logic [SIZE_W-1:0] size,
				logic [FIDX_W-1:0] fidx, logic fnull);
			reply_t            r;
			logic [LINK_W-1:0] link;
			r = '0;
			r.status = STAT_OK;
			if (!started) begin
				if (grow(cfg.start_chunk))
					started = 1;
				else
					r.status = STAT_LIMIT;
			end
			if (r.status == STAT_OK) begin
				if (act == ACT_ALLOC) begin
					if (size > cfg.object_size) begin
						r.status = STAT_OVERSIZE;
					end else begin
						if (!listed) begin
							// a zero-entry growth leaves nothing to hand out
							if (!grow(cfg.expand_chunk) || !listed)
								r.status = STAT_LIMIT;
						end
						if (r.status == STAT_OK) begin
							link = links[head];
							r.handle = head;
							if (link[IDX_W]) begin
								listed = 0;
								head = '0;
							end else begin
								head = link[IDX_W-1:0];
							end
							allocs++;
							held_blocks.push_back(r.handle);
						end
					end
				end else if (fnull) begin
					r.status = STAT_NULL;
				end else begin
					// pushed unchecked, double frees and foreign indices alike
					links[fidx] = listed ? {1'b0, head} : END_LINK;
					head = fidx;
					listed = 1;
					frees++;
				end
			end
			r.pool = POOL_W'(pool);
			r.allocs = allocs;
			r.frees = frees;
			status_tally[r.status]++;
			requests++;
			replies_due.push_back(r);
		endfunction

		function string show(reply_t r);
			return $sformatf("handle=%0d status=%0d pool=%0d allocs=%0d frees=%0d",
				r.handle, r.status, r.pool, r.allocs, r.frees);
		endfunction

		function void check_reply(logic [HANDLE_W-1:0] h, logic [1:0] s,
				logic [POOL_W-1:0] p, logic [CNT_W-1:0] a, logic [CNT_W-1:0] f);
			reply_t got;
			reply_t want;
			got = {h, s, p, a, f};
			if (replies_due.size() == 0) begin
				flag($sformatf("reply with none due: %s", show(got)));
				return;
			end
			want = replies_due.pop_front();
			if (got.handle !== want.handle || got.status !== want.status ||
					got.pool !== want.pool || got.allocs !== want.allocs ||
					got.frees !== want.frees)
				flag($sformatf("reply %0d expected %s, got %s", checked, show(want),
					show(got)));
			checked++;
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start = 1'b0;
	logic                busy;
	logic                action = ACT_ALLOC;
	logic [SIZE_W-1:0]   request_size = '0;
	logic [FIDX_W-1:0]   free_index = '0;
	logic                free_null = 1'b0;
	logic                done;
	logic [HANDLE_W-1:0] handle;
	logic [1:0]          status;
	logic [POOL_W-1:0]   pool_size;
	logic [CNT_W-1:0]    alloc_count;
	logic [CNT_W-1:0]    free_count;

	int unsigned stall_cycles = 0;
	bit          steady = 1'b0;

	free_list_tracker pool_ref = new();

	free_list_pool_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.request_size (request_size),
		.free_index   (free_index),
		.free_null    (free_null),
		.done         (done),
		.handle       (handle),
		.status       (status),
		.pool_size    (pool_size),
		.alloc_count  (alloc_count),
		.free_count   (free_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// replies are checked before the new beat is noted at a shared edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				pool_ref.check_reply(handle, status, pool_size, alloc_count, free_count);
			if (start && !busy)
				pool_ref.take_request(action, request_size, free_index, free_null);
			if (done || (start && !busy))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge; returns at a falling edge after the beat
	task automatic send_item(input logic act, input logic [SIZE_W-1:0] size,
			input logic [FIDX_W-1:0] fidx, input logic fnull);
		int gap;
		action = act;
		request_size = size;
		free_index = fidx;
		free_null = fnull;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic alloc(input logic [SIZE_W-1:0] size);
		send_item(ACT_ALLOC, size, FIDX_W'($urandom), 1'($urandom));
	endtask

	task automatic release_block(input logic [FIDX_W-1:0] idx, input logic fnull);
		send_item(ACT_FREE, SIZE_W'($urandom), idx, fnull);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (pool_ref.replies_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		pool_ref.write_reg(idx, value);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata !== pool_ref.reg_value(idx))
			pool_ref.flag($sformatf("register %0d read %0h, expected %0h", idx, prdata,
				pool_ref.reg_value(idx)));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_limits(input logic [SIZE_W-1:0] obj, input logic [CHUNK_W-1:0] first,
			input logic [CHUNK_W-1:0] step, input logic [CHUNK_W-1:0] cap);
		wait_drained();
		write_reg(REG_OBJECT_SIZE, DATA_W'(obj));
		write_reg(REG_START_CHUNK, DATA_W'(first));
		write_reg(REG_EXPAND_CHUNK, DATA_W'(step));
		write_reg(REG_MAX_POOL, DATA_W'(cap));
	endtask

	// mostly allocs and frees of blocks held, with some unchecked and null frees
	task automatic run_phase(input int beats, input int alloc_pct);
		int          sent;
		int          r;
		int          k;
		int unsigned blk;
		sent = 0;
		while (sent < beats) begin
			if (sent == beats / 2)
				wait_drained();
			r = $urandom_range(0, 99);
			if (r < alloc_pct) begin
				if ($urandom_range(0, 4) == 0)
					alloc(SIZE_W'($urandom));
				else
					alloc(SIZE_W'($urandom_range(0, pool_ref.cfg.object_size)));
				sent++;
			end else if (r < 92 && pool_ref.held_blocks.size() > 0) begin
				k = $urandom_range(0, pool_ref.held_blocks.size() - 1);
				blk = pool_ref.held_blocks[k];
				pool_ref.held_blocks.delete(k);
				release_block(FIDX_W'(blk), 1'b0);
				sent++;
			end else if (r < 96) begin
				release_block(FIDX_W'($urandom), 1'b0);
				sent++;
			end else begin
				release_block(FIDX_W'($urandom), 1'b1);
			end
		end
	endtask

	initial begin
		int alloc_pct;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// initial growth over the limit: every beat refused, retried next time
		set_limits(16'hFFFF, 11'd1024, 11'd1024, 11'd1023);
		alloc(16'd0);
		release_block(10'd5, 1'b0);
		release_block(10'd9, 1'b1);
		// empty initial growth succeeds, then the expansion overruns the cap
		set_limits(16'hFFFF, 11'd0, 11'd1024, 11'd0);
		alloc(16'hFFFF);
		// expansion of zero entries has nothing to give
		set_limits(16'hFFFF, 11'd0, 11'd0, 11'd1024);
		alloc(16'd3);
		set_limits(16'd1, 11'd0, 11'd3, 11'd1024);
		alloc(16'd2);
		alloc(16'd1);
		alloc(16'd0);
		alloc(16'd1);
		alloc(16'd0);
		release_block(10'd1023, 1'b1);
		release_block(10'd1023, 1'b0);
		alloc(16'd1);
		release_block(10'd0, 1'b0);
		release_block(10'd0, 1'b0);
		alloc(16'd0);
		alloc(16'd0);
		alloc(16'd1);
		alloc(16'd1);
		alloc(16'hFFFF);
		// cap lands exactly one entry above the current pool
		set_limits(16'hFFFF, 11'd1024, 11'd1, 11'd7);
		alloc(16'hFFFF);
		alloc(16'd0);
		release_block(10'd6, 1'b0);
		alloc(16'hFFFF);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					set_limits(16'd64, 11'd64, 11'd32, 11'd1024);
					alloc_pct = 55;
				end
				1: begin
					set_limits(SIZE_W'($urandom_range(1, 65535)),
						CHUNK_W'($urandom_range(0, 1024)), 11'd1, 11'd1024);
					alloc_pct = 50;
				end
				2: begin
					set_limits(16'd1, 11'd0, 11'd7, 11'd300);
					alloc_pct = 70;
				end
				3: begin
					set_limits(16'hFFFF, 11'd1024, 11'd1024, 11'd1024);
					alloc_pct = 50;
				end
				4: begin
					set_limits(16'd200, CHUNK_W'($urandom_range(0, 1024)),
						CHUNK_W'($urandom_range(16, 128)), 11'd1024);
					alloc_pct = 80;
				end
				default: begin
					set_limits(16'd64, 11'd64, 11'd32, 11'd1024);
					alloc_pct = 45;
				end
			endcase
			steady = (ph == 1);
			run_phase(222, alloc_pct);
		end
		steady = 1'b0;

		wait_drained();
		repeat (10) @(negedge clk);
		if (pool_ref.replies_due.size() != 0)
			pool_ref.flag($sformatf("%0d replies never came", pool_ref.replies_due.size()));

		$display("covered %0d requests: %0d ok, %0d oversize, %0d at pool limit, %0d null frees",
			pool_ref.requests, pool_ref.status_tally[STAT_OK],
			pool_ref.status_tally[STAT_OVERSIZE], pool_ref.status_tally[STAT_LIMIT],
			pool_ref.status_tally[STAT_NULL]);
		$display("pool reached %0d entries, %0d blocks handed out, %0d frees, %0d reg writes",
			pool_ref.peak, pool_ref.allocs, pool_ref.frees, pool_ref.reg_writes);
		if (pool_ref.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
